/* rtl/tls_pkg.sv */
// Shared types, constants and saturating helpers for the text line statistics block.
// No dependencies; used by every module under rtl/.
package tls_pkg;

   localparam int COUNT_BITS = 32;
   localparam int NUM_DELIMS = 7;
   localparam int STAT_BITS  = 5;
   localparam int VALUE_BITS = 32;
   localparam int ENC_BITS   = 3;

   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [STAT_BITS-1:0]  stat_id_type;

   // Statistic identifiers, in emission order
   localparam stat_id_type STAT_LINES    = 5'd0;
   localparam stat_id_type STAT_LF       = 5'd1;
   localparam stat_id_type STAT_CRLF     = 5'd2;
   localparam stat_id_type STAT_MAXLEN   = 5'd3;
   localparam stat_id_type STAT_LENSUM   = 5'd4;
   localparam stat_id_type STAT_EMPTY    = 5'd5;
   localparam stat_id_type STAT_ASCII    = 5'd6;
   localparam stat_id_type STAT_NONASCII = 5'd7;
   localparam stat_id_type STAT_COMMA    = 5'd8;
   localparam stat_id_type STAT_SPACE    = 5'd14;
   localparam stat_id_type STAT_ENCODING = 5'd15;
   localparam stat_id_type STAT_BOM      = 5'd16;
   localparam stat_id_type STAT_BYTES    = 5'd17;

   // Encoding codes
   localparam logic [ENC_BITS-1:0] ENC_ASCII    = 3'd0;
   localparam logic [ENC_BITS-1:0] ENC_UTF8     = 3'd1;
   localparam logic [ENC_BITS-1:0] ENC_UTF8_BOM = 3'd2;
   localparam logic [ENC_BITS-1:0] ENC_U16_LE   = 3'd3;
   localparam logic [ENC_BITS-1:0] ENC_U16_BE   = 3'd4;

   // Characters of interest
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] BOM8_0     = 8'hEF;
   localparam logic [7:0] BOM8_1     = 8'hBB;
   localparam logic [7:0] BOM8_2     = 8'hBF;
   localparam logic [7:0] BOM16_FF   = 8'hFF;
   localparam logic [7:0] BOM16_FE   = 8'hFE;

   // Delimiters: comma, semicolon, colon, equals, tab, pipe, space
   localparam logic [NUM_DELIMS-1:0][7:0] DELIM_CHARS =
      {8'h20, 8'h7C, 8'h09, 8'h3D, 8'h3A, 8'h3B, 8'h2C};

   // Counter state handed from the front to the back at end of file
   typedef struct packed {
      count_type                       bytes;
      count_type                       newlines;
      count_type                       crlfs;
      count_type                       cur_len;
      count_type                       longest;
      count_type                       len_sum;
      count_type                       empties;
      count_type                       high_bytes;
      logic [NUM_DELIMS-1:0][COUNT_BITS-1:0] delims;
      logic [23:0]                     lead;
      logic                            final_nl;
   } snap_type;

   function automatic count_type sat_inc(input count_type a);
      return (&a) ? a : a + COUNT_BITS'(1);
   endfunction

   function automatic count_type sat_add(input count_type a, input count_type b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
   endfunction

   // Clamp a counter to the 32-bit report width
   function automatic logic [VALUE_BITS-1:0] clamp_value(input count_type v);
      logic [COUNT_BITS+VALUE_BITS-1:0] w;
      w = {{VALUE_BITS{1'b0}}, v};
      if (w[COUNT_BITS+VALUE_BITS-1:VALUE_BITS] != '0) begin
         return '1;
      end
      return w[VALUE_BITS-1:0];
   endfunction

endpackage

/* rtl/tls_front.sv */
// Front end: accepts bytes and updates the running per-file counters.
// Depends on tls_pkg; hands a counter snapshot to tls_queue at end of file.
module tls_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        data_byte,
   input  logic              end_of_file,
   input  logic              queue_full,
   output logic              byte_ready,
   output logic              snap_push,
   output tls_pkg::snap_type snap_data
);

   tls_pkg::count_type bytes_ff, bytes_in;
   tls_pkg::count_type nl_ff, nl_in;
   tls_pkg::count_type crlf_ff, crlf_in;
   tls_pkg::count_type cur_ff, cur_in;
   tls_pkg::count_type longest_ff, longest_in;
   tls_pkg::count_type sum_ff, sum_in;
   tls_pkg::count_type empty_ff, empty_in;
   tls_pkg::count_type high_ff, high_in;
   logic [tls_pkg::NUM_DELIMS-1:0][tls_pkg::COUNT_BITS-1:0] delim_ff, delim_in;
   logic [23:0]        lead_ff, lead_in;
   logic               prev_cr_ff, prev_cr_in;

   logic               take;
   logic               is_nl;
   tls_pkg::count_type trimmed_len;

   assign byte_ready = !queue_full;
   assign take       = byte_valid && byte_ready;
   assign is_nl      = (data_byte == tls_pkg::CHAR_LF);

   // Counter values after this byte
   always_comb begin
      bytes_in   = tls_pkg::sat_inc(bytes_ff);
      high_in    = data_byte[7] ? tls_pkg::sat_inc(high_ff) : high_ff;
      lead_in    = lead_ff;
      if (bytes_ff < tls_pkg::COUNT_BITS'(3)) begin
         case (bytes_ff[1:0])
            2'd0:    lead_in[7:0]   = data_byte;
            2'd1:    lead_in[15:8]  = data_byte;
            default: lead_in[23:16] = data_byte;
         endcase
      end
      for (int k = 0; k < tls_pkg::NUM_DELIMS; k++) begin
         delim_in[k] = (data_byte == tls_pkg::DELIM_CHARS[k]) ?
                       tls_pkg::sat_inc(delim_ff[k]) : delim_ff[k];
      end

      // Strip a carriage return that ends the line
      trimmed_len = (prev_cr_ff && cur_ff != '0) ? cur_ff - tls_pkg::COUNT_BITS'(1) : cur_ff;
      nl_in      = nl_ff;
      crlf_in    = crlf_ff;
      sum_in     = sum_ff;
      longest_in = longest_ff;
      empty_in   = empty_ff;
      cur_in     = tls_pkg::sat_inc(cur_ff);
      if (is_nl) begin
         nl_in      = tls_pkg::sat_inc(nl_ff);
         crlf_in    = (prev_cr_ff && cur_ff != '0) ? tls_pkg::sat_inc(crlf_ff) : crlf_ff;
         sum_in     = tls_pkg::sat_add(sum_ff, trimmed_len);
         longest_in = (trimmed_len > longest_ff) ? trimmed_len : longest_ff;
         empty_in   = (trimmed_len == '0) ? tls_pkg::sat_inc(empty_ff) : empty_ff;
         cur_in     = '0;
      end
      prev_cr_in = (data_byte == tls_pkg::CHAR_CR);
   end

   assign snap_push           = take && end_of_file;
   assign snap_data.bytes      = bytes_in;
   assign snap_data.newlines   = nl_in;
   assign snap_data.crlfs      = crlf_in;
   assign snap_data.cur_len    = cur_in;
   assign snap_data.longest    = longest_in;
   assign snap_data.len_sum    = sum_in;
   assign snap_data.empties    = empty_in;
   assign snap_data.high_bytes = high_in;
   assign snap_data.delims     = delim_in;
   assign snap_data.lead       = lead_in;
   assign snap_data.final_nl   = is_nl;

   always_ff @(posedge clock) begin
      if (reset || snap_push) begin
         bytes_ff   <= '0;
         nl_ff      <= '0;
         crlf_ff    <= '0;
         cur_ff     <= '0;
         longest_ff <= '0;
         sum_ff     <= '0;
         empty_ff   <= '0;
         high_ff    <= '0;
         delim_ff   <= '0;
         lead_ff    <= '0;
         prev_cr_ff <= 1'b0;
      end else if (take) begin
         bytes_ff   <= bytes_in;
         nl_ff      <= nl_in;
         crlf_ff    <= crlf_in;
         cur_ff     <= cur_in;
         longest_ff <= longest_in;
         sum_ff     <= sum_in;
         empty_ff   <= empty_in;
         high_ff    <= high_in;
         delim_ff   <= delim_in;
         lead_ff    <= lead_in;
         prev_cr_ff <= prev_cr_in;
      end
   end

endmodule

/* rtl/tls_queue.sv */
// Two-entry snapshot queue between the counting front and the reporting back.
// Depends on tls_pkg for the snapshot type.
module tls_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tls_pkg::snap_type push_data,
   input  logic              pop,
   output logic              full,
   output logic              not_empty,
   output tls_pkg::snap_type head
);

   tls_pkg::snap_type entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

/* rtl/tls_back.sv */
// Back end: settles the final line and walks one snapshot out as 18 statistics.
// Depends on tls_pkg; reads the head of tls_queue and drives the result register.
module tls_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          snap_valid,
   input  tls_pkg::snap_type             snap,
   output logic                          snap_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output tls_pkg::stat_id_type          rsp_id,
   output logic [tls_pkg::VALUE_BITS-1:0] rsp_value,
   output logic                          rsp_last
);

   tls_pkg::stat_id_type          idx_ff;
   logic                          valid_ff;
   tls_pkg::stat_id_type          id_ff;
   logic [tls_pkg::VALUE_BITS-1:0] value_ff;
   logic                          last_ff;

   logic                          load;
   logic                          at_last;
   tls_pkg::count_type            stat_value;
   tls_pkg::count_type            hi_nl;
   logic [tls_pkg::ENC_BITS-1:0]  enc;
   logic [2:0]                    delim_sel;

   assign load     = snap_valid && (!valid_ff || rsp_ready);
   assign at_last  = (idx_ff == tls_pkg::STAT_BYTES);
   assign snap_pop = load && at_last;

   assign rsp_valid = valid_ff;
   assign rsp_id    = id_ff;
   assign rsp_value = value_ff;
   assign rsp_last  = last_ff;

   // Encoding from the leading bytes
   always_comb begin
      if (snap.bytes >= tls_pkg::COUNT_BITS'(3) && snap.lead[7:0] == tls_pkg::BOM8_0 &&
          snap.lead[15:8] == tls_pkg::BOM8_1 && snap.lead[23:16] == tls_pkg::BOM8_2) begin
         enc = tls_pkg::ENC_UTF8_BOM;
      end else if (snap.bytes >= tls_pkg::COUNT_BITS'(2) &&
                   snap.lead[7:0] == tls_pkg::BOM16_FF &&
                   snap.lead[15:8] == tls_pkg::BOM16_FE) begin
         enc = tls_pkg::ENC_U16_LE;
      end else if (snap.bytes >= tls_pkg::COUNT_BITS'(2) &&
                   snap.lead[7:0] == tls_pkg::BOM16_FE &&
                   snap.lead[15:8] == tls_pkg::BOM16_FF) begin
         enc = tls_pkg::ENC_U16_BE;
      end else begin
         enc = (snap.high_bytes == '0) ? tls_pkg::ENC_ASCII : tls_pkg::ENC_UTF8;
      end
   end

   assign hi_nl     = tls_pkg::sat_add(snap.high_bytes, snap.newlines);
   assign delim_sel = 3'(idx_ff - tls_pkg::STAT_COMMA);

   always_comb begin
      case (idx_ff) inside
         tls_pkg::STAT_LINES:
            stat_value = snap.final_nl ? snap.newlines : tls_pkg::sat_inc(snap.newlines);
         tls_pkg::STAT_LF:
            stat_value = (snap.newlines > snap.crlfs) ? snap.newlines - snap.crlfs : '0;
         tls_pkg::STAT_CRLF:
            stat_value = snap.crlfs;
         tls_pkg::STAT_MAXLEN:
            stat_value = (!snap.final_nl && snap.cur_len > snap.longest) ?
                         snap.cur_len : snap.longest;
         tls_pkg::STAT_LENSUM:
            stat_value = snap.final_nl ? snap.len_sum :
                         tls_pkg::sat_add(snap.len_sum, snap.cur_len);
         tls_pkg::STAT_EMPTY:
            stat_value = snap.empties;
         tls_pkg::STAT_ASCII:
            stat_value = (snap.bytes > hi_nl) ? snap.bytes - hi_nl : '0;
         tls_pkg::STAT_NONASCII:
            stat_value = snap.high_bytes;
         [tls_pkg::STAT_COMMA:tls_pkg::STAT_SPACE]:
            stat_value = snap.delims[delim_sel];
         tls_pkg::STAT_ENCODING:
            stat_value = tls_pkg::COUNT_BITS'(enc);
         tls_pkg::STAT_BOM:
            stat_value = (enc >= tls_pkg::ENC_UTF8_BOM) ? tls_pkg::COUNT_BITS'(1) : '0;
         default:
            stat_value = snap.bytes;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= tls_pkg::STAT_LINES;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff   <= at_last ? tls_pkg::STAT_LINES : idx_ff + 5'd1;
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         id_ff    <= idx_ff;
         value_ff <= tls_pkg::clamp_value(stat_value);
         last_ff  <= at_last;
      end
   end

endmodule

/* rtl/text_line_statistics.sv */
// Text line statistics: top level joining the counting front, snapshot queue and report back.
// Depends on tls_pkg, tls_front, tls_queue and tls_back.
//
// The block takes a file one byte per transaction on the req_ stream, with req_tlast on the
// final byte, and keeps byte, line-feed, CRLF, line length, empty line, high byte and
// delimiter counts, all saturating. The final byte of a file leaves its counters as a
// snapshot in a two-deep queue and clears them, so the next file may start on the very next
// cycle. The report side drains one snapshot as 18 rsp_ transactions in id order (lines,
// lf, crlf, maxlen, lensum, empty, ascii, nonascii, seven delimiters, encoding, bom, bytes),
// one per cycle while rsp_tready is high, rsp_tlast on the last. Input rate is one byte per
// cycle; req_tready drops only while both queue entries hold undelivered reports, i.e. when
// files shorter than a report arrive back to back or rsp_ stalls. Reset needs no clearing pass.
module text_line_statistics (
   input  logic        clock,
   input  logic        reset,
   // byte input
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_file
   // statistics output
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] stat_id, [36:5] stat_value, [39:37] zero
   output logic        rsp_tlast    // run_last
);

   tls_pkg::snap_type             push_snap;
   tls_pkg::snap_type             head_snap;
   logic                          push;
   logic                          pop;
   logic                          q_full;
   logic                          q_valid;
   tls_pkg::stat_id_type          stat_id;
   logic [tls_pkg::VALUE_BITS-1:0] stat_value;

   // Counting front: one byte per transaction
   tls_front u_front (
      .clock       (clock),
      .reset       (reset),
      .byte_valid  (req_tvalid),
      .data_byte   (req_tdata),
      .end_of_file (req_tlast),
      .queue_full  (q_full),
      .byte_ready  (req_tready),
      .snap_push   (push),
      .snap_data   (push_snap)
   );

   // Per-file snapshots waiting to be reported
   tls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_snap),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (head_snap)
   );

   // Report back: 18 statistics per snapshot through a registered output
   tls_back u_back (
      .clock      (clock),
      .reset      (reset),
      .snap_valid (q_valid),
      .snap       (head_snap),
      .snap_pop   (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_id     (stat_id),
      .rsp_value  (stat_value),
      .rsp_last   (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, stat_value, stat_id};

endmodule

/* tb/tb_text_line_statistics.sv */
// Self-checking testbench for text_line_statistics: streams files into req_ and checks
// every rsp_ statistic against an in-bench tally of the same counts.
// Depends on tls_pkg and the text_line_statistics RTL.
`timescale 1ns / 1ps

module tb_text_line_statistics;

   localparam int NUM_STATS      = 18;
   localparam int WATCHDOG_LIMIT = 3000;   // idle cycles allowed with no transaction
   localparam int STALL_CYCLES   = 400;    // long rsp_ hold-off in the stall test
   localparam int TAIL_CYCLES    = 40;     // settle time after the last report

   typedef struct {
      tls_pkg::stat_id_type id;
      logic [31:0]          value;
      logic                 last;
   } stat_entry_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] data_byte
   logic        req_tlast = 1'b0;     // end_of_file
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;            // [4:0] stat_id, [36:5] stat_value, [39:37] zero
   logic        rsp_tlast;            // run_last

   // Running tally of the current file, mirrors the block's counters
   tls_pkg::count_type n_bytes, n_lf, n_crlf, run_len, max_len, len_total, n_empty, n_high;
   tls_pkg::count_type n_delim [tls_pkg::NUM_DELIMS];
   logic [23:0] head_bytes;
   logic        last_cr;

   stat_entry_type pending_stats[$];
   logic [7:0]     file_bytes[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   logic stall_request = 1'b0;
   int stall_left = 0;
   int mismatches = 0;
   int stats_checked = 0;
   int files_sent = 0;
   int bytes_sent = 0;
   int input_stalls = 0;
   int quiet_cycles = 0;

   text_line_statistics u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------- tally
   function automatic tls_pkg::count_type sat_up(input tls_pkg::count_type a);
      return (a == '1) ? a : a + tls_pkg::COUNT_BITS'(1);
   endfunction

   function automatic tls_pkg::count_type sat_sum(input tls_pkg::count_type a,
                                                  input tls_pkg::count_type b);
      logic [tls_pkg::COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[tls_pkg::COUNT_BITS] ? '1 : s[tls_pkg::COUNT_BITS-1:0];
   endfunction

   task automatic clear_tally();
      n_bytes = '0; n_lf = '0; n_crlf = '0; run_len = '0; max_len = '0;
      len_total = '0; n_empty = '0; n_high = '0;
      foreach (n_delim[k]) n_delim[k] = '0;
      head_bytes = '0;
      last_cr = 1'b0;
   endtask

   task automatic close_line(input tls_pkg::count_type len, input logic may_be_empty);
      len_total = sat_sum(len_total, len);
      if (len > max_len) max_len = len;
      if (may_be_empty && len == '0) n_empty = sat_up(n_empty);
   endtask

   // Fold one accepted byte into the tally; on end of file queue the 18 statistics
   task automatic tally_byte(input logic [7:0] b, input logic eof);
      tls_pkg::count_type len, lines, ascii, hi_nl;
      tls_pkg::count_type vals [NUM_STATS];
      logic [2:0]  enc;
      stat_entry_type e;
      if (n_bytes < 3) head_bytes[8*n_bytes[1:0] +: 8] = b;
      n_bytes = sat_up(n_bytes);
      if (b[7]) n_high = sat_up(n_high);
      for (int k = 0; k < tls_pkg::NUM_DELIMS; k++) begin
         if (b == tls_pkg::DELIM_CHARS[k]) n_delim[k] = sat_up(n_delim[k]);
      end
      if (b == tls_pkg::CHAR_LF) begin
         len = run_len;
         n_lf = sat_up(n_lf);
         // CR right before LF is a CRLF ending, not part of the line
         if (last_cr && len != '0) begin
            n_crlf = sat_up(n_crlf);
            len = len - tls_pkg::COUNT_BITS'(1);
         end
         close_line(len, 1'b1);
         run_len = '0;
      end else begin
         run_len = sat_up(run_len);
      end
      last_cr = (b == tls_pkg::CHAR_CR);
      if (!eof) return;

      // Unterminated last line counts, keeps any trailing CR, never empty
      lines = n_lf;
      if (b != tls_pkg::CHAR_LF) begin
         lines = sat_up(lines);
         close_line(run_len, 1'b0);
      end
      hi_nl = sat_sum(n_high, n_lf);
      ascii = (n_bytes > hi_nl) ? n_bytes - hi_nl : '0;

      if (n_bytes >= 3 &&
          head_bytes == {tls_pkg::BOM8_2, tls_pkg::BOM8_1, tls_pkg::BOM8_0})
         enc = tls_pkg::ENC_UTF8_BOM;
      else if (n_bytes >= 2 && head_bytes[15:0] == {tls_pkg::BOM16_FE, tls_pkg::BOM16_FF})
         enc = tls_pkg::ENC_U16_LE;
      else if (n_bytes >= 2 && head_bytes[15:0] == {tls_pkg::BOM16_FF, tls_pkg::BOM16_FE})
         enc = tls_pkg::ENC_U16_BE;
      else
         enc = (n_high == '0) ? tls_pkg::ENC_ASCII : tls_pkg::ENC_UTF8;

      vals[tls_pkg::STAT_LINES]    = lines;
      vals[tls_pkg::STAT_LF]       = (n_lf > n_crlf) ? n_lf - n_crlf : '0;
      vals[tls_pkg::STAT_CRLF]     = n_crlf;
      vals[tls_pkg::STAT_MAXLEN]   = max_len;
      vals[tls_pkg::STAT_LENSUM]   = len_total;
      vals[tls_pkg::STAT_EMPTY]    = n_empty;
      vals[tls_pkg::STAT_ASCII]    = ascii;
      vals[tls_pkg::STAT_NONASCII] = n_high;
      for (int k = 0; k < tls_pkg::NUM_DELIMS; k++)
         vals[tls_pkg::STAT_COMMA + k] = n_delim[k];
      vals[tls_pkg::STAT_ENCODING] = tls_pkg::count_type'(enc);
      vals[tls_pkg::STAT_BOM]      = (enc >= tls_pkg::ENC_UTF8_BOM) ?
                                     tls_pkg::COUNT_BITS'(1) : '0;
      vals[tls_pkg::STAT_BYTES]    = n_bytes;

      for (int k = 0; k < NUM_STATS; k++) begin
         e.id    = tls_pkg::stat_id_type'(k);
         e.value = vals[k];   // counters are 32 bits, no clamp needed
         e.last  = (k == NUM_STATS - 1);
         pending_stats.insert(pending_stats.size(), e);
      end
      clear_tally();
   endtask

   // ---------------------------------------------------------------- driving
   // Called at a falling edge; returns at the falling edge after acceptance with
   // req_tvalid still high, so the caller either sends again or lowers it.
   task automatic send_byte(input logic [7:0] b, input logic eof);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eof;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tally_byte(b, eof);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
      files_sent++;
   endtask

   task automatic add_byte(input logic [7:0] b);
      file_bytes.insert(file_bytes.size(), b);
   endtask

   // Mostly text-like content: words, delimiters, LF and CRLF endings, stray CRs,
   // high bytes, an occasional byte-order mark, plus some raw noise
   task automatic make_random_file(input int max_bytes);
      int n, pick;
      file_bytes.delete();
      pick = $urandom_range(99);
      if (pick < 85)      n = $urandom_range(1, (max_bytes < 8) ? max_bytes : 8);
      else if (pick < 97) n = $urandom_range(1, (max_bytes < 30) ? max_bytes : 30);
      else                n = $urandom_range(1, max_bytes);
      if ($urandom_range(99) < 10) begin
         case ($urandom_range(3))
            0: file_bytes = '{tls_pkg::BOM8_0, tls_pkg::BOM8_1, tls_pkg::BOM8_2};
            1: file_bytes = '{tls_pkg::BOM16_FF, tls_pkg::BOM16_FE};
            2: file_bytes = '{tls_pkg::BOM16_FE, tls_pkg::BOM16_FF};
            default: file_bytes = '{tls_pkg::BOM8_0, tls_pkg::BOM8_1};
         endcase
      end
      while (file_bytes.size() < n) begin
         pick = $urandom_range(99);
         if (pick < 38)      add_byte(8'($urandom_range(8'h61, 8'h7A)));
         else if (pick < 52)
            add_byte(tls_pkg::DELIM_CHARS[$urandom_range(tls_pkg::NUM_DELIMS-1)]);
         else if (pick < 62) add_byte(tls_pkg::CHAR_LF);
         else if (pick < 70) begin
            add_byte(tls_pkg::CHAR_CR);
            add_byte(tls_pkg::CHAR_LF);
         end
         else if (pick < 75) add_byte(tls_pkg::CHAR_CR);
         else if (pick < 85) add_byte(8'($urandom_range(8'h80, 8'hFF)));
         else                add_byte(8'($urandom_range(255)));
      end
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   // Receiver: random back-pressure, or a long counted hold-off on request
   always @(negedge clock) begin
      if (stall_request) begin
         stall_left = STALL_CYCLES;
         stall_request = 1'b0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------- checking
   task automatic flag_mismatch(input string what, input logic [39:0] exp_v,
                                input logic [39:0] got_v);
      mismatches++;
      if (mismatches <= 10)
         $display("%0t: mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, what,
                  exp_v, got_v);
   endtask

   always @(posedge clock) begin
      stat_entry_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_stats.size() == 0) begin
            flag_mismatch("unexpected statistic transaction", '0, rsp_tdata);
         end else begin
            e = pending_stats.pop_front();
            stats_checked++;
            if (rsp_tdata[4:0] !== e.id)
               flag_mismatch("stat_id", 40'(e.id), 40'(rsp_tdata[4:0]));
            if (rsp_tdata[36:5] !== e.value)
               flag_mismatch($sformatf("stat_value of id %0d", e.id), 40'(e.value),
                             40'(rsp_tdata[36:5]));
            if (rsp_tdata[39:37] !== 3'b000)
               flag_mismatch("tdata padding", '0, 40'(rsp_tdata[39:37]));
            if (rsp_tlast !== e.last)
               flag_mismatch($sformatf("run_last of id %0d", e.id), 40'(e.last),
                             40'(rsp_tlast));
         end
      end
   end

   // Watchdog on cycles without any transaction; also counts input stalls
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (!reset && req_tvalid && !req_tready) input_stalls++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles, %0d statistics outstanding",
                  $realtime, quiet_cycles, pending_stats.size());
         $display("tb_text_line_statistics failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests
   // Edge cases: one-byte files, lone LF, CRLF empty line, trailing CR, every
   // byte-order mark including a truncated one, all delimiters, byte extremes
   task automatic test_directed();
      file_bytes = '{8'h41};                                    send_file();
      file_bytes = '{tls_pkg::CHAR_LF};                         send_file();
      file_bytes = '{tls_pkg::CHAR_CR, tls_pkg::CHAR_LF};       send_file();
      file_bytes = '{8'h61, tls_pkg::CHAR_CR};                  send_file();
      file_bytes = '{tls_pkg::BOM8_0, tls_pkg::BOM8_1, tls_pkg::BOM8_2};
      send_file();
      file_bytes = '{tls_pkg::BOM16_FF, tls_pkg::BOM16_FE};     send_file();
      file_bytes = '{tls_pkg::BOM16_FE, tls_pkg::BOM16_FF};     send_file();
      file_bytes = '{tls_pkg::BOM8_0, tls_pkg::BOM8_1};         send_file();
      file_bytes = '{8'h2C, 8'h3B, 8'h3A, 8'h3D, 8'h09, 8'h7C, 8'h20,
                     8'h00, 8'h7F, 8'h80};
      send_file();
   endtask

   task automatic test_random_text(input int byte_budget);
      int stop_at;
      stop_at = bytes_sent + byte_budget;
      while (bytes_sent < stop_at) begin
         make_random_file(80);
         send_file();
      end
   endtask

   // Hold rsp_ off while short files keep coming, so the snapshot queue fills
   task automatic test_output_stall();
      req_tvalid <= 1'b0;
      @(posedge clock);
      stall_request = 1'b1;
      @(negedge clock);
      repeat (8) begin
         make_random_file(3);
         send_file();
      end
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (pending_stats.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   initial begin
      clear_tally();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      set_idle(19, 70);
      test_directed();
      test_random_text(95);
      set_idle(70, 19);
      test_random_text(95);
      set_idle(0, 0);
      test_output_stall();
      test_random_text(90);
      wait_drain();

      if (pending_stats.size() != 0) mismatches++;
      $display("Sent %0d files (%0d bytes) under mixed idling and a %0d-cycle output stall,",
               files_sent, bytes_sent, STALL_CYCLES);
      $display("checked %0d statistics, saw %0d input stall cycles, %0d mismatches.",
               stats_checked, input_stalls, mismatches);
      if (mismatches == 0) begin
         $display("tb_text_line_statistics passed");
      end else begin
         $display("tb_text_line_statistics failed");
      end
      $finish;
   end

endmodule

/* text_line_statistics.f */
rtl/tls_pkg.sv
rtl/tls_front.sv
rtl/tls_queue.sv
rtl/tls_back.sv
rtl/text_line_statistics.sv
tb/tb_text_line_statistics.sv
